[hdl/erlt_pkg.sv]
// Package for the extent reader/writer lock table.
// Holds operation and status codes and the front-to-back request type.
// No dependencies.
`default_nettype none
package erlt_pkg;
  localparam logic [2:0] OP_RD_LOCK   = 3'd0;
  localparam logic [2:0] OP_WR_LOCK   = 3'd1;
  localparam logic [2:0] OP_DOWNGRADE = 3'd2;
  localparam logic [2:0] OP_RD_UNLOCK = 3'd3;
  localparam logic [2:0] OP_WR_UNLOCK = 3'd4;
  localparam logic [2:0] OP_QUERY     = 3'd5;
  localparam logic [2:0] OP_FIND      = 3'd6;
  localparam logic [2:0] OP_UNUSED    = 3'd7;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_CONFLICT    = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_WRONG_STATE = 3'd4;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] tag;
    logic        clear_dirty;
  } req_t;
endpackage
`default_nettype wire

[hdl/erlt_front.sv]
// Front end: accepts requests and queues them for the table engine.
// Depends on erlt_pkg.
`default_nettype none
module erlt_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [2:0]      in_operation,
  input  wire logic [63:0]     in_tag,
  input  wire logic            in_mark_clean,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output erlt_pkg::req_t       q_req
);
  import erlt_pkg::*;

  // two-deep queue
  req_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  // store payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{op: in_operation, tag: in_tag, clear_dirty: in_mark_clean};
    end
  end
endmodule
`default_nettype wire

[hdl/erlt_back.sv]
// Back end: table of entries, tag match, lock update and find-dirty scan.
// Depends on erlt_pkg.
`default_nettype none
module erlt_back #(
  parameter int ENTRIES     = 16,
  parameter int MAX_READERS = 255
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire erlt_pkg::req_t  q_req,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_granted,
  output logic [2:0]           out_status,
  output logic                 out_is_dirty,
  output logic                 out_found,
  output logic [63:0]          out_found_tag
);
  import erlt_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int HW = $clog2(MAX_READERS + 1) + 1;
  localparam logic [HW-1:0] H_WR  = '1;
  localparam logic [HW-1:0] H_MAX = HW'(MAX_READERS);
  localparam logic [IW-1:0] LAST  = IW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  req_t              req_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [63:0]       tag_r [ENTRIES];
  logic              dirty_r [ENTRIES];
  logic [HW-1:0]     hold_r [ENTRIES];
  logic [IW-1:0]     start_r, start_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [IW:0]       left_r, left_nxt;
  logic              hit_r, free_ok_r;
  logic [IW-1:0]     hit_idx_r, free_idx_r;
  logic              hit_c, free_c;
  logic [IW-1:0]     hit_idx_c, free_idx_c;
  logic              g_r, g_nxt, d_r, d_nxt, f_r, f_nxt;
  logic [2:0]        st_r, st_nxt;
  logic [63:0]       ft_r, ft_nxt;
  logic              we;
  logic [IW-1:0]     widx;
  logic [63:0]       wtag;
  logic              wdirty;
  logic [HW-1:0]     whold, h;

  assign q_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_granted = g_r;
  assign out_status = st_r;
  assign out_is_dirty = d_r;
  assign out_found = f_r;
  assign out_found_tag = ft_r;

  // match all tags and find lowest free slot for the incoming request
  always_comb begin
    hit_c = 1'b0; hit_idx_c = '0; free_c = 1'b0; free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == q_req.tag) begin
        hit_c = 1'b1; hit_idx_c = IW'(i);
      end
      if (!valid_r[i]) begin
        free_c = 1'b1; free_idx_c = IW'(i);
      end
    end
  end

  assign h = hold_r[hit_idx_r];

  always_comb begin
    state_nxt = state_r; valid_nxt = valid_r; start_nxt = start_r;
    k_nxt = k_r; left_nxt = left_r;
    g_nxt = g_r; st_nxt = st_r; d_nxt = d_r; f_nxt = f_r; ft_nxt = ft_r;
    we = 1'b0; widx = hit_idx_r; wtag = req_r.tag; wdirty = dirty_r[hit_idx_r];
    whold = h;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_req.op == OP_FIND) ? S_SCAN : S_EXEC;
          k_nxt = start_r; left_nxt = (IW+1)'(ENTRIES);
          g_nxt = 1'b0; st_nxt = ST_OK; d_nxt = 1'b0; f_nxt = 1'b0; ft_nxt = '0;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        case (req_r.op)
          OP_RD_LOCK, OP_WR_LOCK: begin
            if (hit_r) begin
              if (req_r.op == OP_WR_LOCK ? (h != '0) : (h == H_WR || h >= H_MAX)) begin
                st_nxt = ST_CONFLICT;
              end else begin
                we = 1'b1; g_nxt = 1'b1;
                if (req_r.op == OP_WR_LOCK) begin
                  wdirty = 1'b1; whold = H_WR;
                end else begin
                  whold = h + HW'(1);
                end
              end
            end else if (!free_ok_r) begin
              st_nxt = ST_FULL;
            end else begin
              we = 1'b1; g_nxt = 1'b1; widx = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
              wdirty = (req_r.op == OP_WR_LOCK);
              whold = (req_r.op == OP_WR_LOCK) ? H_WR : HW'(1);
            end
          end
          OP_DOWNGRADE, OP_RD_UNLOCK, OP_WR_UNLOCK, OP_QUERY: begin
            if (!hit_r) st_nxt = ST_NOT_FOUND;
            else begin
              case (req_r.op)
                OP_DOWNGRADE: begin
                  if (h != H_WR) st_nxt = ST_WRONG_STATE;
                  else begin we = 1'b1; whold = HW'(1); g_nxt = 1'b1; end
                end
                OP_RD_UNLOCK: begin
                  if (h == H_WR || h == '0) st_nxt = ST_WRONG_STATE;
                  else begin we = 1'b1; whold = h - HW'(1); g_nxt = 1'b1; end
                end
                OP_WR_UNLOCK: begin
                  if (h != H_WR) st_nxt = ST_WRONG_STATE;
                  else begin
                    we = 1'b1; whold = '0; g_nxt = 1'b1;
                    if (req_r.clear_dirty) wdirty = 1'b0;
                  end
                end
                default: begin
                  d_nxt = dirty_r[hit_idx_r]; g_nxt = 1'b1;
                end
              endcase
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // visit one slot a cycle
        if (left_r == '0) state_nxt = S_OUT;
        else begin
          left_nxt = left_r - (IW+1)'(1);
          k_nxt = (k_r == LAST) ? '0 : k_r + IW'(1);
          if (valid_r[k_r] && hold_r[k_r] == '0) begin
            if (dirty_r[k_r]) begin
              f_nxt = 1'b1; g_nxt = 1'b1; ft_nxt = tag_r[k_r];
              start_nxt = k_r; state_nxt = S_OUT;
            end else begin
              valid_nxt[k_r] = 1'b0;
            end
          end
        end
      end
      default: begin
        if (out_ready) state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; start_r <= '0;
    end else begin
      state_r <= state_nxt; valid_r <= valid_nxt; start_r <= start_nxt;
    end
  end

  // payload and entry fields
  always_ff @(posedge clk) begin
    k_r <= k_nxt; left_r <= left_nxt;
    g_r <= g_nxt; st_r <= st_nxt; d_r <= d_nxt; f_r <= f_nxt; ft_r <= ft_nxt;
    if (state_r == S_IDLE && q_valid) begin
      req_r <= q_req; hit_r <= hit_c; hit_idx_r <= hit_idx_c;
      free_ok_r <= free_c; free_idx_r <= free_idx_c;
    end
    if (we) begin
      tag_r[widx] <= wtag; dirty_r[widx] <= wdirty; hold_r[widx] <= whold;
    end
  end
endmodule
`default_nettype wire

[hdl/extent_rw_lock_table_unit.sv]
// Extent reader/writer lock table: lock, unlock, query and find-dirty requests.
// Lock and query requests: the result follows the queue, match and update steps.
// Find dirty runs a scan of up to ENTRIES slots, one slot per cycle.
// Only one request is in the engine at a time; a new one is taken once the last result is accepted.
// Synchronous active-low reset empties the table and sets the scan start to slot 0.
// Depends on erlt_pkg, erlt_front and erlt_back.
`default_nettype none
module extent_rw_lock_table_unit #(
  parameter int ENTRIES     = 16,
  parameter int MAX_READERS = 255
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [63:0] in_tag,
  input  wire logic        in_mark_clean,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_granted,
  output logic [2:0]       out_status,
  output logic             out_is_dirty,
  output logic             out_found,
  output logic [63:0]      out_found_tag
);
  import erlt_pkg::*;

  logic q_valid, q_ready;
  req_t q_req;

  erlt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_tag, .in_mark_clean,
    .q_valid, .q_ready, .q_req
  );

  erlt_back #(.ENTRIES(ENTRIES), .MAX_READERS(MAX_READERS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_req, .out_valid, .out_ready,
    .out_granted, .out_status, .out_is_dirty, .out_found, .out_found_tag
  );

`ifndef SYNTH
  a_found_granted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_granted && out_status == ST_OK)
    else $error("found without grant");
  a_notfound_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_tag == 64'd0)
    else $error("tag without find");
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> out_status == ST_OK)
    else $error("grant with error status");
`endif
endmodule
`default_nettype wire
